/* rtl/rvmc_pkg.sv */
// ----------------------------------------------------------------------------
// rvmc_pkg
// Shared constants and immediate decoders for the multicycle RV32IM executor.
// ----------------------------------------------------------------------------
`default_nettype none

package rvmc_pkg;

  // Data memory size in bytes; must be a power of two so that addresses wrap
  // by masking.
  localparam int unsigned DATA_BYTES = 4096;
  localparam int          DMEM_AW    = $clog2(DATA_BYTES);

  // Major opcodes.
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;

  // funct7 groups.
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // funct3 codes for register and immediate arithmetic.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes for multiply and divide.
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_REM  = 3'd6;

  // funct3 codes for memory access sizes.
  localparam logic [2:0] F3_HALF = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;

  // funct3 codes for branches.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Immediate decoders, all sign extended to 32 bits.
  function automatic logic [31:0] imm_i(input logic [31:0] ins);
    return {{20{ins[31]}}, ins[31:20]};
  endfunction

  function automatic logic [31:0] imm_s(input logic [31:0] ins);
    return {{20{ins[31]}}, ins[31:25], ins[11:7]};
  endfunction

  function automatic logic [31:0] imm_b(input logic [31:0] ins);
    return {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] ins);
    return {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  endfunction

endpackage

`default_nettype wire

/* rtl/rv32im_multicycle_executor.sv */
// ----------------------------------------------------------------------------
// rv32im_multicycle_executor
// Executes one RV32IM instruction per beat against a register file, a program
// counter and a byte-wide data memory, under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one instruction word per beat. The output channel
//   returns one beat per instruction with the next pc, the destination write
//   and the halt flag. The configuration channel writes start_address, which
//   also loads the pc at once; write it only while the block is idle.
//   From input beat to output beat, ALU, branch and jump instructions pass
//   through S_RS2, S_EXEC and S_WB; loads and stores add S_MEM, one data
//   memory byte per cycle; mul, mulh, div and rem add S_MD and S_MDFIX and
//   run 32 steps of one shared add/subtract unit. The block holds one
//   instruction at a time and does not take a new one until the previous
//   one has finished. After reset the block sweeps the data memory to zero,
//   one byte a cycle, over all DATA_BYTES (4096) bytes; no instruction is
//   taken meanwhile, while configuration writes are.
//   A finished result sits in the output register; a new instruction can be
//   taken while it waits, but that instruction's result is held back until
//   the receiver takes the previous beat.
//   Unsupported words set a sticky halt; later beats change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32im_multicycle_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] start_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_pc,
  output logic        dest_written,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        halted
);
  import rvmc_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RS2   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MEM   = 3'd4;
  localparam logic [2:0] S_MD    = 3'd5;
  localparam logic [2:0] S_MDFIX = 3'd6;
  localparam logic [2:0] S_WB    = 3'd7;

  localparam logic [DMEM_AW-1:0] DMEM_LAST = DMEM_AW'(DATA_BYTES - 1);

  logic [2:0]  state;
  logic [31:0] ir;
  logic [31:0] pc;
  logic        halt_flag;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] res_val;
  logic [31:0] res_npc;
  logic        res_wr;
  logic        res_bad;
  logic [31:0] mem_addr;
  logic [4:0]  cnt;
  logic [DMEM_AW-1:0] clr_idx;

  // Shared multiply/divide unit registers.
  logic [31:0] md_hi;
  logic [31:0] md_lo;
  logic [31:0] md_opb;
  logic        md_div;

  // Register file storage with per-entry valid bits.
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld;
  logic [31:0] rf_q;
  logic        rf_qv;
  logic [4:0]  rf_raddr;
  logic [31:0] rf_rd;

  // Data memory.
  logic [7:0]         dm_mem [DATA_BYTES];
  logic [7:0]         dm_q;
  logic [DMEM_AW-1:0] dm_addr;
  logic               dm_we;
  logic [7:0]         dm_wdata;

  // Instruction fields.
  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;
  assign opc = ir[6:0];
  assign f3  = ir[14:12];
  assign f7  = ir[31:25];
  assign rd  = ir[11:7];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  logic cfg_fire;
  logic in_fire;
  logic wb_fire;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire  = in_valid && in_ready;
  assign wb_fire  = (state == S_WB) && (!out_valid || out_ready);

  // Register file read port: rs1 while idle, rs2 afterwards.
  assign rf_raddr = (state == S_IDLE) ? instruction[19:15] : ir[24:20];
  assign rf_rd    = rf_qv ? rf_q : 32'd0;

  always_ff @(posedge clk) begin
    rf_q  <= rf_mem[rf_raddr];
    rf_qv <= rf_vld[rf_raddr];
  end

  // Write-back decision for the destination register.
  logic wr_eff;
  assign wr_eff = res_wr && (rd != 5'd0) && !halt_flag && !res_bad;

  always_ff @(posedge clk) begin
    if (wb_fire && wr_eff) begin
      rf_mem[rd] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (wb_fire && wr_eff) begin
      rf_vld[rd] <= 1'b1;
    end
  end

  // Execute-stage decode and simple ALU, branch and jump results.
  logic [31:0] pc4;
  logic [31:0] ex_val;
  logic [31:0] ex_npc;
  logic        ex_wr;
  logic        ex_bad;
  logic        ex_mem;
  logic        ex_md;
  logic        ex_take;
  logic [31:0] b_val;

  assign pc4   = pc + 32'd4;
  assign b_val = rf_rd;

  always_comb begin
    ex_val  = 32'd0;
    ex_npc  = pc4;
    ex_wr   = 1'b0;
    ex_bad  = 1'b0;
    ex_mem  = 1'b0;
    ex_md   = 1'b0;
    ex_take = 1'b0;
    unique case (opc)
      OP_REG: begin
        ex_wr = 1'b1;
        unique case (f7)
          F7_BASE: begin
            unique case (f3)
              F3_ADD:  ex_val = op_a + b_val;
              F3_SLL:  ex_val = op_a << b_val[4:0];
              F3_SLT:  ex_val = {31'd0, $signed(op_a) < $signed(b_val)};
              F3_SLTU: ex_val = {31'd0, op_a < b_val};
              F3_XOR:  ex_val = op_a ^ b_val;
              F3_SRL:  ex_val = op_a >> b_val[4:0];
              F3_OR:   ex_val = op_a | b_val;
              default: ex_val = op_a & b_val;
            endcase
          end
          F7_ALT: begin
            if (f3 == F3_ADD) begin
              ex_val = op_a - b_val;
            end else if (f3 == F3_SRL) begin
              ex_val = 32'($signed(op_a) >>> b_val[4:0]);
            end else begin
              ex_bad = 1'b1;
            end
          end
          F7_MULDIV: begin
            if (f3 == F3_MUL || f3 == F3_MULH || f3 == F3_DIV || f3 == F3_REM) begin
              ex_md = 1'b1;
            end else begin
              ex_bad = 1'b1;
            end
          end
          default: ex_bad = 1'b1;
        endcase
      end
      OP_IMM: begin
        if (f3 == F3_ADD) begin
          ex_wr  = 1'b1;
          ex_val = op_a + imm_i(ir);
        end else begin
          ex_bad = 1'b1;
        end
      end
      OP_LOAD: begin
        if (f3 == F3_HALF || f3 == F3_WORD) begin
          ex_wr  = 1'b1;
          ex_mem = 1'b1;
        end else begin
          ex_bad = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 == F3_HALF || f3 == F3_WORD) begin
          ex_mem = 1'b1;
        end else begin
          ex_bad = 1'b1;
        end
      end
      OP_BRANCH: begin
        unique case (f3)
          F3_BEQ:  ex_take = (op_a == b_val);
          F3_BNE:  ex_take = (op_a != b_val);
          F3_BLT:  ex_take = $signed(op_a) < $signed(b_val);
          F3_BGE:  ex_take = !($signed(op_a) < $signed(b_val));
          F3_BLTU: ex_take = op_a < b_val;
          F3_BGEU: ex_take = op_a >= b_val;
          default: ex_bad  = 1'b1;
        endcase
        if (ex_take) begin
          ex_npc = pc + imm_b(ir);
        end
      end
      OP_LUI: begin
        ex_wr  = 1'b1;
        ex_val = {ir[31:12], 12'd0};
      end
      OP_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc + {ir[31:12], 12'd0};
      end
      OP_JAL: begin
        ex_wr  = 1'b1;
        ex_val = pc4;
        ex_npc = pc + imm_j(ir);
      end
      OP_JALR: begin
        if (f3 == F3_ADD) begin
          ex_wr  = 1'b1;
          ex_val = pc4;
          ex_npc = (op_a + imm_i(ir)) & ~32'd1;
        end else begin
          ex_bad = 1'b1;
        end
      end
      default: ex_bad = 1'b1;
    endcase
  end

  // Operand magnitudes for the signed multiply/divide setup.
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  assign mag_a = op_a[31] ? (32'd0 - op_a) : op_a;
  assign mag_b = b_val[31] ? (32'd0 - b_val) : b_val;

  // Shared add/subtract unit: shift-add multiply or restoring divide step.
  logic [32:0] rem_sh;
  logic [33:0] add_x;
  logic [33:0] add_y;
  logic [33:0] add_s;
  logic        div_ge;
  logic [32:0] mul_top;

  assign rem_sh  = {md_hi, md_lo[31]};
  assign add_x   = md_div ? {1'b0, rem_sh} : {2'b00, md_hi};
  assign add_y   = md_div ? ~{2'b00, md_opb} : {2'b00, md_opb};
  assign add_s   = add_x + add_y + {33'd0, md_div};
  assign div_ge  = ~add_s[33];
  assign mul_top = md_lo[0] ? add_s[32:0] : {1'b0, md_hi};

  // Sign and special-case correction of the unit's result.
  logic [63:0] prod;
  logic [63:0] prod_s;
  logic [31:0] md_res;
  assign prod   = {md_hi, md_lo};
  assign prod_s = (op_a[31] ^ op_b[31]) ? (64'd0 - prod) : prod;

  always_comb begin
    case (f3)
      F3_MUL:  md_res = prod_s[31:0];
      F3_MULH: md_res = prod_s[63:32];
      F3_DIV: begin
        if (op_b == 32'd0) begin
          md_res = 32'hFFFF_FFFF;
        end else begin
          md_res = (op_a[31] ^ op_b[31]) ? (32'd0 - md_lo) : md_lo;
        end
      end
      default: begin
        if (op_b == 32'd0) begin
          md_res = op_a;
        end else begin
          md_res = op_a[31] ? (32'd0 - md_hi) : md_hi;
        end
      end
    endcase
  end

  // Byte sequencing for loads and stores.
  logic        is_store;
  logic [2:0]  mem_n;
  logic [1:0]  lb_idx;
  assign is_store = (opc == OP_STORE);
  assign mem_n    = (f3 == F3_WORD) ? 3'd4 : 3'd2;
  assign lb_idx   = cnt[1:0] - 2'd1;

  assign dm_we    = (state == S_CLEAR) ||
                    ((state == S_MEM) && is_store);
  assign dm_wdata = (state == S_CLEAR) ? 8'd0 : op_b[8*cnt[1:0] +: 8];
  assign dm_addr  = (state == S_CLEAR) ? clr_idx :
                    mem_addr[DMEM_AW-1:0] + DMEM_AW'(cnt[1:0]);

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_addr] <= dm_wdata;
    end
    dm_q <= dm_mem[dm_addr];
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pc        <= 32'd0;
      halt_flag <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= 5'd0;
    end else begin
      // The output beat is raised on write-back and dropped once taken.
      if (wb_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + DMEM_AW'(1);
          if (clr_idx == DMEM_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            ir    <= instruction;
            state <= halt_flag ? S_WB : S_RS2;
          end
        end
        S_RS2: begin
          op_a  <= rf_rd;
          state <= S_EXEC;
        end
        S_EXEC: begin
          op_b     <= b_val;
          res_val  <= ex_val;
          res_npc  <= ex_npc;
          res_wr   <= ex_wr;
          res_bad  <= ex_bad;
          mem_addr <= op_a + (is_store ? imm_s(ir) : imm_i(ir));
          cnt      <= 5'd0;
          md_hi    <= 32'd0;
          md_div   <= f3[2];
          if (f3[2]) begin
            md_opb <= mag_b;
            md_lo  <= mag_a;
          end else begin
            md_opb <= mag_a;
            md_lo  <= mag_b;
          end
          if (ex_bad) begin
            state <= S_WB;
          end else if (ex_md) begin
            state <= S_MD;
          end else if (ex_mem) begin
            state <= S_MEM;
          end else begin
            state <= S_WB;
          end
        end
        S_MEM: begin
          cnt <= cnt + 5'd1;
          if (is_store) begin
            if (cnt == {2'b00, mem_n - 3'd1}) begin
              state <= S_WB;
            end
          end else if (cnt == {2'b00, mem_n}) begin
            if (f3 == F3_WORD) begin
              res_val <= {dm_q, res_val[23:0]};
            end else begin
              res_val <= {{16{dm_q[7]}}, dm_q, res_val[7:0]};
            end
            state <= S_WB;
          end else if (cnt != 5'd0) begin
            res_val[8*lb_idx +: 8] <= dm_q;
          end
        end
        S_MD: begin
          cnt <= cnt + 5'd1;
          if (md_div) begin
            md_hi <= div_ge ? add_s[31:0] : rem_sh[31:0];
            md_lo <= {md_lo[30:0], div_ge};
          end else begin
            md_hi <= mul_top[32:1];
            md_lo <= {mul_top[0], md_lo[31:1]};
          end
          if (cnt == 5'd31) begin
            state <= S_MDFIX;
          end
        end
        S_MDFIX: begin
          res_val <= md_res;
          state   <= S_WB;
        end
        S_WB: begin
          if (wb_fire) begin
            state <= S_IDLE;
            if (!halt_flag && res_bad) begin
              halt_flag <= 1'b1;
            end else if (!halt_flag) begin
              pc <= res_npc;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // Configuration loads the start address into the pc.
      if (cfg_fire) begin
        pc <= start_address;
      end
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (wb_fire) begin
      if (halt_flag || res_bad) begin
        next_pc      <= pc;
        dest_written <= 1'b0;
        dest_index   <= 5'd0;
        dest_value   <= 32'd0;
        halted       <= 1'b1;
      end else begin
        next_pc      <= res_npc;
        dest_written <= wr_eff;
        dest_index   <= wr_eff ? rd : 5'd0;
        dest_value   <= wr_eff ? res_val : 32'd0;
        halted       <= 1'b0;
      end
    end
  end

  // Checks on the sequencer and result bookkeeping.
  a_x0_never_valid: assert property (@(posedge clk) disable iff (rst)
    !rf_vld[0])
    else $error("register x0 marked as written");

  a_dest_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dest_written) |-> (dest_index != 5'd0 && !halted))
    else $error("destination write reported for x0 or while halted");

  a_halt_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (halted == halt_flag))
    else $error("reported halt differs from halt flag");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("instruction accepted during memory clear");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halt_flag) && !$past(rst) |-> halt_flag)
    else $error("halt flag cleared without reset");

endmodule

`default_nettype wire

/* tb/rv32im_multicycle_executor_tb.sv */
// ----------------------------------------------------------------------------
// rv32im_multicycle_executor_tb
// Checks the executor against an instruction-level model kept inside the
// bench. The sender streams instruction words and the receiver takes the
// retire beats. Each retire beat is compared field by field with the model's
// prediction. The run moves through several start addresses and idle patterns
// and ends with a halting word and a few words sent while halted.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32im_multicycle_executor_tb;
  import rvmc_pkg::*;

  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        halt;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] start_address = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instruction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] next_pc;
  logic        dest_written;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic        halted;

  // Architectural state of the model.
  logic [31:0] arch_regs [32];
  logic [7:0]  arch_mem [DATA_BYTES];
  logic [31:0] arch_pc;
  logic        arch_halt;

  logic [31:0] insn_q [$];
  retire_t     retire_q [$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_req = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic        in_taken = 1'b0;

  rv32im_multicycle_executor u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .start_address(start_address),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .instruction  (instruction),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_pc      (next_pc),
    .dest_written (dest_written),
    .dest_index   (dest_index),
    .dest_value   (dest_value),
    .halted       (halted)
  );

  always #10 clk = ~clk;

  // Instruction encoders.
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // Reads and writes the model memory byte by byte; each address wraps alone.
  function automatic logic [31:0] mem_read(logic [31:0] addr, int nbytes);
    logic [31:0] v;
    logic [31:0] a;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      a = addr + i;
      v[8*i +: 8] = arch_mem[a[DMEM_AW-1:0]];
    end
    return v;
  endfunction

  task automatic mem_write(input logic [31:0] addr, input logic [31:0] v, input int nbytes);
    logic [31:0] a;
    for (int i = 0; i < nbytes; i++) begin
      a = addr + i;
      arch_mem[a[DMEM_AW-1:0]] = v[8*i +: 8];
    end
  endtask

  // Executes one instruction on the model and returns the retire beat.
  task automatic execute(input logic [31:0] ins, output retire_t r);
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, npc, val, imm, h;
    logic [63:0] prod;
    logic        wr, bad, take;
    op = ins[6:0];
    rd = ins[11:7];
    f3 = ins[14:12];
    f7 = ins[31:25];
    a = arch_regs[ins[19:15]];
    b = arch_regs[ins[24:20]];
    npc = arch_pc + 32'd4;
    val = '0;
    wr = 1'b0;
    bad = 1'b0;
    take = 1'b0;
    if (!arch_halt) begin
      case (op)
        OP_REG: begin
          wr = 1'b1;
          if (f7 == F7_BASE) begin
            case (f3)
              F3_ADD:  val = a + b;
              F3_SLL:  val = a << b[4:0];
              F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
              F3_SLTU: val = {31'd0, a < b};
              F3_XOR:  val = a ^ b;
              F3_SRL:  val = a >> b[4:0];
              F3_OR:   val = a | b;
              default: val = a & b;
            endcase
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            val = a - b;
          end else if (f7 == F7_ALT && f3 == F3_SRL) begin
            val = $signed(a) >>> b[4:0];
          end else if (f7 == F7_MULDIV && f3 == F3_MUL) begin
            val = a * b;
          end else if (f7 == F7_MULDIV && f3 == F3_MULH) begin
            prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
            val = prod[63:32];
          end else if (f7 == F7_MULDIV && (f3 == F3_DIV || f3 == F3_REM)) begin
            // Divide by zero and the one signed overflow case are defined results.
            if (b == 0)
              val = (f3 == F3_DIV) ? 32'hFFFF_FFFF : a;
            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
              val = (f3 == F3_DIV) ? 32'h8000_0000 : 32'd0;
            else if (f3 == F3_DIV)
              val = $signed(a) / $signed(b);
            else
              val = $signed(a) % $signed(b);
          end else begin
            bad = 1'b1;
          end
        end
        OP_IMM: begin
          if (f3 == F3_ADD) begin
            wr = 1'b1;
            val = a + {{20{ins[31]}}, ins[31:20]};
          end else begin
            bad = 1'b1;
          end
        end
        OP_LOAD: begin
          imm = {{20{ins[31]}}, ins[31:20]};
          if (f3 == F3_HALF) begin
            wr = 1'b1;
            h = mem_read(a + imm, 2);
            val = {{16{h[15]}}, h[15:0]};
          end else if (f3 == F3_WORD) begin
            wr = 1'b1;
            val = mem_read(a + imm, 4);
          end else begin
            bad = 1'b1;
          end
        end
        OP_STORE: begin
          imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
          if (f3 == F3_HALF) mem_write(a + imm, b, 2);
          else if (f3 == F3_WORD) mem_write(a + imm, b, 4);
          else bad = 1'b1;
        end
        OP_BRANCH: begin
          imm = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
          case (f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = $signed(a) < $signed(b);
            F3_BGE:  take = !($signed(a) < $signed(b));
            F3_BLTU: take = (a < b);
            F3_BGEU: take = (a >= b);
            default: bad = 1'b1;
          endcase
          if (take) npc = arch_pc + imm;
        end
        OP_LUI: begin
          wr = 1'b1;
          val = {ins[31:12], 12'd0};
        end
        OP_AUIPC: begin
          wr = 1'b1;
          val = arch_pc + {ins[31:12], 12'd0};
        end
        OP_JAL: begin
          wr = 1'b1;
          val = arch_pc + 32'd4;
          npc = arch_pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
        end
        OP_JALR: begin
          if (f3 == F3_ADD) begin
            wr = 1'b1;
            val = arch_pc + 32'd4;
            npc = (a + {{20{ins[31]}}, ins[31:20]}) & ~32'd1;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
      // A bad word halts with the pc left on it; otherwise commit.
      if (bad) begin
        arch_halt = 1'b1;
      end else begin
        arch_pc = npc;
        if (wr && rd != 0) arch_regs[rd] = val;
      end
    end
    if (!wr || rd == 0 || arch_halt) begin
      wr = 1'b0;
      rd = '0;
      val = '0;
    end
    r = '{npc: arch_pc, wr: wr, idx: rd, val: val, halt: arch_halt};
  endtask

  // Random well-formed instruction with a bias toward a small memory window.
  function automatic logic [31:0] random_insn();
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    logic [2:0]  f3;
    rd = 5'($urandom_range(31));
    rs1 = 5'($urandom_range(31));
    rs2 = 5'($urandom_range(31));
    imm = 12'($urandom);
    case ($urandom_range(15))
      0, 1: return enc_r(F7_BASE, rs2, rs1, 3'($urandom_range(7)), rd);
      2: return enc_r(F7_ALT, rs2, rs1, $urandom_range(1) ? F3_ADD : F3_SRL, rd);
      3: begin
        case ($urandom_range(3))
          0: f3 = F3_MUL;
          1: f3 = F3_MULH;
          2: f3 = F3_DIV;
          default: f3 = F3_REM;
        endcase
        return enc_r(F7_MULDIV, rs2, rs1, f3, rd);
      end
      4, 5: return enc_i(imm, rs1, F3_ADD, rd, OP_IMM);
      6: return {20'($urandom_range(32'hFFFFF)), rd, OP_LUI};
      7: return {20'($urandom_range(32'hFFFFF)), rd, OP_AUIPC};
      8, 9: begin
        if ($urandom_range(1)) begin
          rs1 = '0;
          imm = 12'($urandom_range(48) - 8);
        end
        return enc_i(imm, rs1, $urandom_range(1) ? F3_HALF : F3_WORD, rd, OP_LOAD);
      end
      10, 11: begin
        if ($urandom_range(1)) begin
          rs1 = '0;
          imm = 12'($urandom_range(48) - 8);
        end
        return enc_s(imm, rs2, rs1, $urandom_range(1) ? F3_HALF : F3_WORD);
      end
      12, 13: begin
        case ($urandom_range(5))
          0: f3 = F3_BEQ;
          1: f3 = F3_BNE;
          2: f3 = F3_BLT;
          3: f3 = F3_BGE;
          4: f3 = F3_BLTU;
          default: f3 = F3_BGEU;
        endcase
        return enc_b(13'($urandom), rs2, rs1, f3);
      end
      14: return enc_j(21'($urandom), rd);
      default: return enc_i(imm, rs1, F3_ADD, rd, OP_JALR);
    endcase
  endfunction

  // Sample side: check retire beats, then predict for accepted words.
  always @(posedge clk) begin
    retire_t want;
    if (!rst) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (retire_q.size() == 0) begin
          $display("%0t: retire beat with nothing expected, pc %h", $time, next_pc);
          errors++;
        end else begin
          want = retire_q.pop_front();
          if (next_pc !== want.npc || dest_written !== want.wr || dest_index !== want.idx ||
              dest_value !== want.val || halted !== want.halt) begin
            $display("%0t: mismatch expected pc %h wr %b rd %0d val %h halt %b", $time,
                     want.npc, want.wr, want.idx, want.val, want.halt);
            $display("%0t:          actual   pc %h wr %b rd %0d val %h halt %b", $time,
                     next_pc, dest_written, dest_index, dest_value, halted);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) arch_pc = start_address;
      if (in_valid && in_ready) begin
        execute(instruction, want);
        retire_q.push_back(want);
      end
    end
  end

  // Instruction driver fed from the pending queue.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (insn_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        instruction <= insn_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Retire receiver with random stalls and a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_served) begin
      hold_served <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic drain();
    while (insn_q.size() != 0 || in_valid || retire_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] addr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    start_address <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) insn_q.push_back(random_insn());
  endtask

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < DATA_BYTES; i++) arch_mem[i] = '0;
    arch_pc = '0;
    arch_halt = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, division corners, memory wrap.
    write_start(32'hFFFF_FFFF);
    insn_q.push_back({20'h80000, 5'd1, OP_LUI});
    insn_q.push_back(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));
    insn_q.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_IMM));
    insn_q.push_back(enc_i(12'h800, 5'd0, F3_ADD, 5'd4, OP_IMM));
    insn_q.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd5));
    insn_q.push_back(enc_r(F7_ALT, 5'd2, 5'd4, F3_ADD, 5'd6));
    insn_q.push_back(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLL, 5'd7));
    insn_q.push_back(enc_r(F7_ALT, 5'd3, 5'd1, F3_SRL, 5'd8));
    for (int f = 0; f < 8; f++) insn_q.push_back(enc_r(F7_BASE, 5'd2, 5'd1, 3'(f), 5'(9 + f)));
    insn_q.push_back(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd17));
    insn_q.push_back(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd18));
    insn_q.push_back(enc_r(F7_MULDIV, 5'd0, 5'd3, F3_DIV, 5'd19));
    insn_q.push_back(enc_r(F7_MULDIV, 5'd0, 5'd3, F3_REM, 5'd20));
    insn_q.push_back(enc_r(F7_MULDIV, 5'd1, 5'd1, F3_MULH, 5'd21));
    insn_q.push_back(enc_r(F7_MULDIV, 5'd4, 5'd3, F3_MUL, 5'd22));
    insn_q.push_back(enc_s(12'hFFE, 5'd5, 5'd0, F3_WORD));
    insn_q.push_back(enc_i(12'hFFF, 5'd0, F3_HALF, 5'd23, OP_LOAD));
    insn_q.push_back(enc_s(12'h7FF, 5'd2, 5'd0, F3_HALF));
    insn_q.push_back(enc_i(12'hFFE, 5'd0, F3_WORD, 5'd24, OP_LOAD));
    insn_q.push_back(enc_b(13'h1FFE, 5'd2, 5'd1, F3_BLT));
    insn_q.push_back(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BGEU));
    insn_q.push_back(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
    insn_q.push_back(enc_b(13'h0008, 5'd0, 5'd0, F3_BNE));
    insn_q.push_back(enc_b(13'h0010, 5'd2, 5'd1, F3_BGE));
    insn_q.push_back(enc_b(13'h0010, 5'd2, 5'd1, F3_BLTU));
    insn_q.push_back({20'hFFFFF, 5'd25, OP_AUIPC});
    insn_q.push_back(enc_j(21'h100000, 5'd26));
    insn_q.push_back(enc_i(12'h7FF, 5'd3, F3_ADD, 5'd27, OP_JALR));
    insn_q.push_back(enc_i(12'h123, 5'd1, F3_ADD, 5'd0, OP_IMM));
    drain();

    // Random phases with changing start address and idle patterns.
    write_start(32'd0);
    send_idle = 70;
    queue_random(375);
    drain();

    write_start($urandom);
    send_idle = 0;
    recv_stall = 70;
    hold_req++;
    queue_random(375);
    drain();

    write_start(32'h7FFF_FFF0);
    send_idle = 16;
    recv_stall = 16;
    queue_random(375);
    drain();

    // Last phase ends on an unsupported word; the words after it are ignored.
    write_start(32'hFFFF_FFFC);
    send_idle = 0;
    recv_stall = 0;
    queue_random(375);
    insn_q.push_back(32'h0000_0000);
    insn_q.push_back(32'hFFFF_FFFF);
    insn_q.push_back(enc_i(12'h001, 5'd0, F3_ADD, 5'd1, OP_IMM));
    insn_q.push_back(enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd2));
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/rvmc_pkg.sv
rtl/rv32im_multicycle_executor.sv
tb/rv32im_multicycle_executor_tb.sv
